// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; included by ean13_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ean13_pkg.sv =====
`default_nettype none
package ean13_pkg;

  localparam int unsigned DIG_W = 4;
  localparam int unsigned MW_W  = 6;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned PIX_W = 13;

  localparam logic [0:0] CFG_CHECK_INCLUDED = 1'd0;
  localparam logic [0:0] CFG_MODULE_WIDTH   = 1'd1;

  typedef enum logic [2:0] {
    REG_QUIET = 3'd0,
    REG_START = 3'd1,
    REG_LEFT  = 3'd2,
    REG_MID   = 3'd3,
    REG_RIGHT = 3'd4,
    REG_CHECK = 3'd5,
    REG_END   = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    CODE_L = 2'd0,
    CODE_G = 2'd1,
    CODE_R = 2'd2
  } code_kind_t;

  typedef struct packed {
    logic       err;
    logic       head;
    logic       mid;
    logic       code2;
    logic       tail;
    region_t    region1;
    logic [6:0] pat1;
    logic [6:0] pat2;
  } job_t;

  function automatic logic [6:0] lcode(input logic [DIG_W-1:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h0D;
      4'd1:    c = 7'h19;
      4'd2:    c = 7'h13;
      4'd3:    c = 7'h3D;
      4'd4:    c = 7'h23;
      4'd5:    c = 7'h31;
      4'd6:    c = 7'h2F;
      4'd7:    c = 7'h3B;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h0B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] parity(input logic [DIG_W-1:0] d);
    logic [5:0] p;
    case (d)
      4'd0:    p = 6'h00;
      4'd1:    p = 6'h0B;
      4'd2:    p = 6'h0D;
      4'd3:    p = 6'h0E;
      4'd4:    p = 6'h13;
      4'd5:    p = 6'h19;
      4'd6:    p = 6'h1C;
      4'd7:    p = 6'h15;
      4'd8:    p = 6'h16;
      4'd9:    p = 6'h1A;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  // Bar pattern, 1 = bar, sent MSB first.
  function automatic logic [6:0] pattern(input logic [DIG_W-1:0] d, input code_kind_t kind);
    logic [6:0] l;
    logic [6:0] r;
    logic [6:0] g;
    logic [6:0] p;
    l = lcode(d);
    r = ~l;
    for (int i = 0; i < 7; i++) begin
      g[6-i] = r[i];
    end
    case (kind)
      CODE_G:  p = g;
      CODE_R:  p = r;
      default: p = l;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ean13_front.sv =====
`default_nettype none
module ean13_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [ean13_pkg::DIG_W-1:0] in_digit,
  input  wire logic                       check_included,
  input  wire logic                       job_full,
  output logic                            job_push,
  output ean13_pkg::job_t                 job
);

  logic [3:0] pos_r, pos_nxt;
  logic [5:0] par_r, par_nxt;
  logic [3:0] sum_r, sum_nxt;

  logic [3:0] pos_eff;
  logic [2:0] par_sel;
  logic [3:0] sum_base;
  logic [5:0] wd;
  logic [5:0] sum_raw;
  logic [3:0] sum_new;
  logic [3:0] chk;

  function automatic logic [3:0] mod10(input logic [5:0] s);
    logic [5:0] t;
    if (s >= 6'd30) begin
      t = s - 6'd30;
    end else if (s >= 6'd20) begin
      t = s - 6'd20;
    end else if (s >= 6'd10) begin
      t = s - 6'd10;
    end else begin
      t = s;
    end
    return t[3:0];
  endfunction

  assign full     = job_full;
  assign job_push = push && !job_full;

  always_comb begin
    pos_eff  = (pos_r > 4'd12) ? 4'd0 : pos_r;
    par_sel  = 3'd6 - pos_eff[2:0];
    sum_base = (pos_eff == 4'd0) ? 4'd0 : sum_r;
    wd       = pos_eff[0] ? (({2'b00, in_digit} << 1) + {2'b00, in_digit}) : {2'b00, in_digit};
    sum_raw  = {2'b00, sum_base} + wd;
    sum_new  = mod10(sum_raw);
    chk      = (sum_new == 4'd0) ? 4'd0 : (4'd10 - sum_new);

    job         = '0;
    job.region1 = ean13_pkg::REG_LEFT;
    pos_nxt     = pos_eff;
    par_nxt     = par_r;
    sum_nxt     = sum_new;

    priority if (in_digit > 4'd9) begin
      job.err = 1'b1;
      pos_nxt = 4'd0;
      par_nxt = 6'd0;
      sum_nxt = 4'd0;
    end else if (pos_eff == 4'd0) begin
      job.head = 1'b1;
      par_nxt  = ean13_pkg::parity(in_digit);
      pos_nxt  = 4'd1;
    end else if (pos_eff <= 4'd6) begin
      job.region1 = ean13_pkg::REG_LEFT;
      job.pat1    = ean13_pkg::pattern(in_digit,
                      par_r[par_sel] ? ean13_pkg::CODE_G : ean13_pkg::CODE_L);
      job.mid     = (pos_eff == 4'd6);
      pos_nxt     = pos_eff + 4'd1;
    end else if (pos_eff <= 4'd11) begin
      job.region1 = ean13_pkg::REG_RIGHT;
      job.pat1    = ean13_pkg::pattern(in_digit, ean13_pkg::CODE_R);
      if (pos_eff == 4'd11 && !check_included) begin
        job.code2 = 1'b1;
        job.tail  = 1'b1;
        job.pat2  = ean13_pkg::pattern(chk, ean13_pkg::CODE_R);
        pos_nxt   = 4'd0;
        par_nxt   = 6'd0;
        sum_nxt   = 4'd0;
      end else begin
        pos_nxt = pos_eff + 4'd1;
      end
    end else begin
      job.region1 = ean13_pkg::REG_CHECK;
      job.pat1    = ean13_pkg::pattern(in_digit, ean13_pkg::CODE_R);
      job.tail    = 1'b1;
      pos_nxt     = 4'd0;
      par_nxt     = 6'd0;
      sum_nxt     = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      par_r <= 6'd0;
      sum_r <= 4'd0;
    end else if (job_push) begin
      pos_r <= pos_nxt;
      par_r <= par_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ean13_job_fifo.sv =====
`default_nettype none
module ean13_job_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  ean13_pkg::job_t      wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output ean13_pkg::job_t      rd_data,
  output logic                 empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ean13_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ean13_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module ean13_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        job_empty,
  input  ean13_pkg::job_t                  job_in,
  output logic                             job_pop,
  input  wire logic [ean13_pkg::MW_W-1:0]  module_width,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             out_module_level,
  output logic [2:0]                       out_region,
  output logic [ean13_pkg::IDX_W-1:0]      out_module_index,
  output logic [ean13_pkg::PIX_W-1:0]      out_pixel_offset,
  output logic                             out_last,
  output logic                             out_error
);

  typedef enum logic [2:0] {
    PH_ERR, PH_QUIET, PH_START, PH_CODE1, PH_MID, PH_CODE2, PH_ENDG, PH_QTAIL
  } phase_t;

  phase_t                       ph_r;
  phase_t                       ph_next;
  phase_t                       ph_first;
  ean13_pkg::job_t              job_r;
  logic                         busy_r;
  logic [3:0]                   cnt_r;
  logic [ean13_pkg::IDX_W-1:0]  mc_r;

  logic                         ov_r;
  logic                         level_r;
  ean13_pkg::region_t           region_r;
  logic [ean13_pkg::IDX_W-1:0]  index_r;
  logic [ean13_pkg::PIX_W-1:0]  offset_r;
  logic                         last_r;
  logic                         error_r;

  logic [3:0]                   len;
  logic                         ph_end;
  logic                         job_done;
  logic [2:0]                   bit_sel;
  logic                         level;
  ean13_pkg::region_t           region;
  logic                         adv;
  logic                         job_end;
  logic                         load;
  logic [ean13_pkg::PIX_W-1:0]  pix;

  always_comb begin
    bit_sel  = 3'd6 - cnt_r[2:0];
    len      = 4'd7;
    level    = 1'b1;
    region   = ean13_pkg::REG_QUIET;
    ph_next  = PH_ERR;
    job_done = 1'b1;
    unique case (ph_r)
      PH_ERR: begin
        len    = 4'd1;
        level  = 1'b0;
      end
      PH_QUIET: begin
        len      = 4'd11;
        ph_next  = PH_START;
        job_done = 1'b0;
      end
      PH_START: begin
        len    = 4'd3;
        level  = cnt_r[0];
        region = ean13_pkg::REG_START;
      end
      PH_CODE1: begin
        level  = ~job_r.pat1[bit_sel];
        region = job_r.region1;
        if (job_r.mid) begin
          ph_next  = PH_MID;
          job_done = 1'b0;
        end else if (job_r.code2) begin
          ph_next  = PH_CODE2;
          job_done = 1'b0;
        end else if (job_r.tail) begin
          ph_next  = PH_ENDG;
          job_done = 1'b0;
        end
      end
      PH_MID: begin
        len    = 4'd5;
        level  = ~cnt_r[0];
        region = ean13_pkg::REG_MID;
      end
      PH_CODE2: begin
        level    = ~job_r.pat2[bit_sel];
        region   = ean13_pkg::REG_CHECK;
        ph_next  = PH_ENDG;
        job_done = 1'b0;
      end
      PH_ENDG: begin
        len      = 4'd3;
        level    = cnt_r[0];
        region   = ean13_pkg::REG_END;
        ph_next  = PH_QTAIL;
        job_done = 1'b0;
      end
      PH_QTAIL: begin
        len = 4'd7;
      end
    endcase
  end

  always_comb begin
    priority if (job_in.err) begin
      ph_first = PH_ERR;
    end else if (job_in.head) begin
      ph_first = PH_QUIET;
    end else begin
      ph_first = PH_CODE1;
    end
  end

  assign ph_end  = (cnt_r == len - 4'd1);
  assign adv     = busy_r && (!ov_r || pop);
  assign job_end = adv && ph_end && job_done;
  assign load    = (!busy_r || job_end) && !job_empty;
  assign job_pop = load;
  assign pix     = {6'd0, mc_r} * {7'd0, module_width};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      ph_r   <= PH_ERR;
      cnt_r  <= 4'd0;
      mc_r   <= '0;
    end else begin
      if (adv) begin
        level_r  <= level;
        region_r <= region;
        index_r  <= (ph_r == PH_ERR) ? '0 : mc_r;
        offset_r <= (ph_r == PH_ERR) ? '0 : pix;
        last_r   <= ph_end && job_done;
        error_r  <= (ph_r == PH_ERR);
        if (ph_r == PH_ERR || (ph_r == PH_QTAIL && ph_end)) begin
          mc_r <= '0;
        end else begin
          mc_r <= mc_r + 7'd1;
        end
        if (ph_end) begin
          cnt_r <= 4'd0;
          if (!job_done) begin
            ph_r <= ph_next;
          end
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
      if (load) begin
        job_r  <= job_in;
        ph_r   <= ph_first;
        busy_r <= 1'b1;
      end else if (job_end) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign empty            = !ov_r;
  assign out_module_level = level_r;
  assign out_region       = region_r;
  assign out_module_index = index_r;
  assign out_pixel_offset = offset_r;
  assign out_last         = last_r;
  assign out_error        = error_r;

  `ASSERT_IMP(a_index_range, clk, rst_n, ov_r, index_r <= 7'd112, "module index past symbol end")
  `ASSERT_IMP(a_error_single, clk, rst_n, ov_r && error_r, last_r && index_r == 7'd0, "error item malformed")
  `ASSERT_CLK(a_tail_restart, clk, rst_n, adv && ph_r == PH_QTAIL && ph_end |=> mc_r == 7'd0, "count kept after symbol end")
  `ASSERT_IMP(a_load_has_job, clk, rst_n, load, !job_empty && (!busy_r || job_end), "job taken without room")

endmodule
`default_nettype wire

// ===== rtl/ean13_module_pattern_generator.sv =====
// EAN-13 module pattern generator. Push the digits of a code one at a time on in_digit; the
// block answers with one item per barcode module on the out_ ports, oldest first, each with
// its level, region, index in the 113-module symbol and pixel offset (index times
// module_width). Output runs at one module per clock while jobs are queued and pop keeps
// up: the first digit gives 14 modules, digits two to six and eight to eleven give 7, the
// seventh 12, the twelfth 24 when the check is computed and 7 otherwise, a supplied check
// 17, an invalid digit a single error item. So a digit yields 1 to 24 module items, about 9
// on average. The front end classifies a digit in the cycle it is taken; a JOB_DEPTH-entry
// job queue sits ahead of the emitter, so digits are taken back to back until it fills;
// with the emitter idle, a digit is queued, loaded into the emitter, then its first item is
// registered at the outputs. Write configuration only while the block is idle.
`default_nettype none
module ean13_module_pattern_generator #(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [ean13_pkg::DIG_W-1:0] in_digit,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             out_module_level,
  output logic [2:0]                       out_region,
  output logic [ean13_pkg::IDX_W-1:0]      out_module_index,
  output logic [ean13_pkg::PIX_W-1:0]      out_pixel_offset,
  output logic                             out_last,
  output logic                             out_error,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [ean13_pkg::MW_W-1:0]  cfg_data
);

  logic                         chk_inc_r;
  logic [ean13_pkg::MW_W-1:0]   mw_r;

  logic                         job_full;
  logic                         job_push;
  ean13_pkg::job_t              job_wr;
  logic                         job_empty;
  logic                         job_pop;
  ean13_pkg::job_t              job_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_inc_r <= 1'b0;
      mw_r      <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ean13_pkg::CFG_CHECK_INCLUDED: chk_inc_r <= cfg_data[0];
        ean13_pkg::CFG_MODULE_WIDTH:   mw_r      <= cfg_data;
      endcase
    end
  end

  ean13_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_digit       (in_digit),
    .check_included (chk_inc_r),
    .job_full       (job_full),
    .job_push       (job_push),
    .job            (job_wr)
  );

  ean13_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  ean13_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (job_empty),
    .job_in           (job_rd),
    .job_pop          (job_pop),
    .module_width     (mw_r),
    .empty            (empty),
    .pop              (pop),
    .out_module_level (out_module_level),
    .out_region       (out_region),
    .out_module_index (out_module_index),
    .out_pixel_offset (out_pixel_offset),
    .out_last         (out_last),
    .out_error        (out_error)
  );

endmodule
`default_nettype wire
